// ----- hdl/pal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    // Number of records the list can hold.
    localparam int LIST_DEPTH = 8;

    // Field widths of one transaction.
    localparam int POS_W   = 4;
    localparam int NAME_W  = 64;
    localparam int SEX_W   = 24;
    localparam int AGE_W   = 8;
    localparam int SCORE_W = 16;
    localparam int OUT_W   = 4;

    // The count must be able to hold the depth itself.
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    // Common width for comparing positions against the count and cell indexes.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOCATE = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // One stored record.
    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [SEX_W-1:0]   sex;
        logic [AGE_W-1:0]   age;
        logic [SCORE_W-1:0] score;
    } rec_t;

    // Per-cell update command; at most one member is set in a cycle.
    typedef struct packed {
        logic load_key;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/positional_array_list.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to eight records held in a row of cells, one record per
// cell. Each input transaction is one operation selected by s_tuser: insert at
// a 1-based position (later records move up one cell), delete at a position
// (later records move down one cell), or locate the first record whose name
// and age equal the key. Every operation yields one result transaction with a
// status, the found position and the list length after the operation; a new
// operation is taken every cycle while the result register is free or being
// drained. The cells compare and shift in parallel, and a locate ends in an
// eight-way first-match select. A failed insert or delete leaves the list
// unchanged.
module positional_array_list (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // Fields from bit 0: position[3:0], key_name[67:4], key_sex[91:68],
    // key_age[99:92], key_score[115:100], zero padding.
    input  wire logic [119:0] s_tdata,
    // Fields from bit 0: mode[1:0].
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0: status[1:0], found_position[5:2], list_length[9:6],
    // zero padding.
    output logic [15:0]       m_tdata
);

    localparam int D = pal_pkg::LIST_DEPTH;

    // Input field decode.
    pal_pkg::mode_t                  mode;
    logic [pal_pkg::POS_W-1:0]       position;
    pal_pkg::rec_t                   key_rec;

    assign mode          = pal_pkg::mode_t'(s_tuser);
    assign position      = s_tdata[3:0];
    assign key_rec.name  = s_tdata[67:4];
    assign key_rec.sex   = s_tdata[91:68];
    assign key_rec.age   = s_tdata[99:92];
    assign key_rec.score = s_tdata[115:100];

    // Control registers.
    logic [pal_pkg::CNT_W-1:0] count_reg;
    logic [pal_pkg::CNT_W-1:0] count_next;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [15:0]               m_tdata_reg;
    logic [15:0]               m_tdata_next;

    logic accept;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Range checks against the current count.
    logic [pal_pkg::CMP_W-1:0] pos_x;
    logic [pal_pkg::CMP_W-1:0] cnt_x;
    logic                      full;
    logic                      ins_range_bad;
    logic                      del_range_bad;
    logic                      ins_ok;
    logic                      del_ok;

    assign pos_x         = pal_pkg::CMP_W'(position);
    assign cnt_x         = pal_pkg::CMP_W'(count_reg);
    assign full          = (cnt_x >= pal_pkg::CMP_W'(D));
    assign ins_range_bad = (pos_x == '0) || (pos_x > pal_pkg::CMP_W'(cnt_x + 1'b1));
    assign del_range_bad = (pos_x == '0) || (pos_x > cnt_x);
    assign ins_ok        = accept && (mode == pal_pkg::MODE_INSERT) && !full && !ins_range_bad;
    assign del_ok        = accept && (mode == pal_pkg::MODE_DELETE) && !del_range_bad;

    // Row of cells, each handing its record to a neighbor on a shift.
    pal_pkg::rec_t      cell_rec   [D];
    logic [D-1:0]       cell_match;

    for (genvar i = 0; i < D; i++) begin : g_cell
        pal_pkg::cell_ctrl_t ctrl;
        pal_pkg::rec_t       left_rec;
        pal_pkg::rec_t       right_rec;

        assign ctrl.load_key   = ins_ok && (pos_x == pal_pkg::CMP_W'(i + 1));
        assign ctrl.take_left  = ins_ok && (pal_pkg::CMP_W'(i) >= pos_x)
                                        && (pal_pkg::CMP_W'(i) <= cnt_x);
        assign ctrl.take_right = del_ok && (pal_pkg::CMP_W'(i + 1) >= pos_x)
                                        && (pal_pkg::CMP_W'(i + 1) < cnt_x);

        if (i == 0) begin : g_first
            assign left_rec = key_rec;
        end else begin : g_mid_l
            assign left_rec = cell_rec[i-1];
        end

        if (i == D - 1) begin : g_last
            assign right_rec = cell_rec[i];
        end else begin : g_mid_r
            assign right_rec = cell_rec[i+1];
        end

        pal_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .key_rec   (key_rec),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .rec       (cell_rec[i]),
            .match     (cell_match[i])
        );
    end

    // First held cell that matches the key.
    logic [pal_pkg::OUT_W-1:0] found_pos;
    always_comb begin
        found_pos = '0;
        for (int k = D - 1; k >= 0; k--) begin
            if (cell_match[k] && (pal_pkg::CMP_W'(k) < cnt_x)) begin
                found_pos = pal_pkg::OUT_W'(k + 1);
            end
        end
    end

    // Count update.
    always_comb begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = pal_pkg::CNT_W'(count_reg + 1'b1);
        end else if (del_ok) begin
            count_next = pal_pkg::CNT_W'(count_reg - 1'b1);
        end
    end

    // Result transaction assembly.
    pal_pkg::status_t          status;
    logic [pal_pkg::OUT_W-1:0] found_out;

    always_comb begin
        status    = pal_pkg::ST_OK;
        found_out = '0;
        case (mode)
            pal_pkg::MODE_INSERT: begin
                if (full) begin
                    status = pal_pkg::ST_FULL;
                end else if (ins_range_bad) begin
                    status = pal_pkg::ST_RANGE;
                end
            end
            pal_pkg::MODE_DELETE: begin
                if (del_range_bad) begin
                    status = pal_pkg::ST_RANGE;
                end
            end
            pal_pkg::MODE_LOCATE: begin
                found_out = found_pos;
            end
            default: begin
                status = pal_pkg::ST_OK;
            end
        endcase
    end

    // Output register: loads on every accepted operation, drains on m_tready.
    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, pal_pkg::OUT_W'(count_next), found_out, status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hdl/pal_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pal_cell (
    input  wire logic              aclk,
    input  pal_pkg::cell_ctrl_t    ctrl,
    input  pal_pkg::rec_t          key_rec,
    input  pal_pkg::rec_t          left_rec,
    input  pal_pkg::rec_t          right_rec,
    output pal_pkg::rec_t          rec,
    output logic                   match
);

    pal_pkg::rec_t rec_reg;
    pal_pkg::rec_t rec_next;

    // Pick the new content: the key, the left neighbor on an insert shift,
    // or the right neighbor on a delete shift.
    always_comb begin
        rec_next = rec_reg;
        if (ctrl.load_key) begin
            rec_next = key_rec;
        end else if (ctrl.take_left) begin
            rec_next = left_rec;
        end else if (ctrl.take_right) begin
            rec_next = right_rec;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    // Locate compares the name and the age only.
    assign match = (rec_reg.name == key_rec.name) && (rec_reg.age == key_rec.age);
    assign rec   = rec_reg;

endmodule

`default_nettype wire

// ----- dv/positional_array_list_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the list block. It keeps its own copy of the list,
// works out the result of every accepted operation, and compares the results
// in order as they leave the block.
module positional_array_list_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    // Fields from bit 0: position, key_name, key_sex, key_age, key_score, padding.
    input  wire logic [119:0] s_tdata,
    // Fields from bit 0: mode.
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0: status, found_position, list_length, padding.
    input  wire logic [15:0]  m_tdata,
    output int                fail_count,
    output int                pending_results
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        pal_pkg::status_t status;
        logic [3:0]       found;
        logic [3:0]       length;
    } list_result_t;

    // Shadow copy of the record list.
    pal_pkg::rec_t roster [pal_pkg::LIST_DEPTH];
    int            roster_len = 0;

    list_result_t expected_results [$];
    int           error_tally = 0;

    // Applies one operation to the shadow list and returns its result.
    function automatic list_result_t apply_list_op(pal_pkg::mode_t op, logic [3:0] pos,
                                                   pal_pkg::rec_t item);
        list_result_t res;
        int j;
        res.status = pal_pkg::ST_OK;
        res.found  = '0;
        case (op)
            pal_pkg::MODE_INSERT: begin
                if (roster_len >= pal_pkg::LIST_DEPTH) begin
                    res.status = pal_pkg::ST_FULL;
                end else if (pos < 1 || pos > roster_len + 1) begin
                    res.status = pal_pkg::ST_RANGE;
                end else begin
                    for (j = roster_len; j >= pos; j--) begin
                        roster[j] = roster[j-1];
                    end
                    roster[pos-1] = item;
                    roster_len++;
                end
            end
            pal_pkg::MODE_DELETE: begin
                if (pos < 1 || pos > roster_len) begin
                    res.status = pal_pkg::ST_RANGE;
                end else begin
                    for (j = pos; j < roster_len; j++) begin
                        roster[j-1] = roster[j];
                    end
                    roster_len--;
                end
            end
            pal_pkg::MODE_LOCATE: begin
                // Only held entries are searched; the first match wins.
                for (j = 0; j < roster_len; j++) begin
                    if (res.found == 0 && roster[j].name == item.name
                            && roster[j].age == item.age) begin
                        res.found = 4'(j + 1);
                    end
                end
            end
            default: begin
            end
        endcase
        res.length = 4'(roster_len);
        return res;
    endfunction

    task automatic report_fault(string what, list_result_t want, list_result_t got);
        error_tally++;
        if (error_tally <= REPORT_LIMIT) begin
            $write("%0t: %s: expected status %0d found %0d length %0d, ",
                   $realtime, what, want.status, want.found, want.length);
            $display("got status %0d found %0d length %0d",
                     got.status, got.found, got.length);
        end
    endtask

    // Results are compared before the new operation is predicted: a result
    // leaving at this edge always belongs to an earlier transaction.
    always @(posedge aclk) begin : watch
        list_result_t  want;
        list_result_t  got;
        pal_pkg::rec_t key;
        if (!aresetn) begin
            roster_len = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = pal_pkg::status_t'(m_tdata[1:0]);
                got.found  = m_tdata[5:2];
                got.length = m_tdata[9:6];
                if (expected_results.size() == 0) begin
                    want = '0;
                    report_fault("result with no operation pending", want, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found
                            || got.length !== want.length) begin
                        report_fault("result mismatch", want, got);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                key.name  = s_tdata[67:4];
                key.sex   = s_tdata[91:68];
                key.age   = s_tdata[99:92];
                key.score = s_tdata[115:100];
                expected_results.push_back(
                    apply_list_op(pal_pkg::mode_t'(s_tuser), s_tdata[3:0], key));
            end
        end
        fail_count      <= error_tally;
        pending_results <= expected_results.size();
    end

endmodule

// ----- dv/positional_array_list_tb.sv -----
`timescale 1ns / 1ps

// Drives list operations into the block with random idling on both channels
// and reports the verdict from the checker's failure count.
module positional_array_list_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PER_PHASE = 100;

    localparam logic [63:0] NAME_ANA  = 64'h0000_0000_0061_6E61;
    localparam logic [63:0] NAME_BOB  = 64'h0000_0000_0062_6F62;
    localparam logic [63:0] NAME_EVE  = 64'h0000_0000_0065_7665;
    localparam logic [63:0] NAME_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [15:0]  m_tdata;

    int fail_count;
    int pending_results;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fill_level     = 0;
    bit growing        = 1'b1;
    int cycle_count    = 0;

    logic [63:0] name_pool [4] = '{NAME_ANA, NAME_BOB, NAME_EVE, 64'h0};
    logic [7:0]  age_pool  [4] = '{8'd0, 8'd30, 8'd31, 8'd255};

    positional_array_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    positional_array_list_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog for a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sends one transaction, with an optional idle gap in front, and returns
    // at the edge where it is accepted. Valid stays high for the next call.
    task automatic issue_op(input pal_pkg::mode_t op, input logic [3:0] pos,
                            input logic [63:0] name,
                            input logic [23:0] sex, input logic [7:0] age,
                            input logic [15:0] score);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, score, age, sex, name, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Track the fill level only to steer the random mix.
        if (op == pal_pkg::MODE_INSERT && fill_level < pal_pkg::LIST_DEPTH
                && pos >= 1 && pos <= fill_level + 1) begin
            fill_level++;
        end else if (op == pal_pkg::MODE_DELETE && pos >= 1 && pos <= fill_level) begin
            fill_level--;
        end
    endtask

    // Mostly well-formed positions, with names and ages drawn from a small
    // pool so that locates hit; the list swings between empty and full.
    task automatic random_op();
        pal_pkg::mode_t op;
        logic [3:0]     pos;
        logic [63:0]    name;
        logic [7:0]     age;
        int             roll;
        if (fill_level == pal_pkg::LIST_DEPTH) begin
            growing = 1'b0;
        end else if (fill_level == 0) begin
            growing = 1'b1;
        end
        roll = $urandom_range(99);
        if (roll < 5) begin
            op = pal_pkg::MODE_NOP;
        end else if (roll < 35) begin
            op = pal_pkg::MODE_LOCATE;
        end else if ($urandom_range(99) < (growing ? 75 : 25)) begin
            op = pal_pkg::MODE_INSERT;
        end else begin
            op = pal_pkg::MODE_DELETE;
        end
        if ($urandom_range(99) < 15 || (op == pal_pkg::MODE_DELETE && fill_level == 0)) begin
            pos = 4'($urandom_range(15, 0));
        end else if (op == pal_pkg::MODE_INSERT) begin
            pos = 4'($urandom_range(fill_level + 1, 1));
        end else begin
            pos = 4'($urandom_range(fill_level, 1));
        end
        name = ($urandom_range(99) < 70) ? name_pool[$urandom_range(3)] : {$urandom, $urandom};
        age  = ($urandom_range(99) < 70) ? age_pool[$urandom_range(3)] : 8'($urandom);
        issue_op(op, pos, name, 24'($urandom), age, 16'($urandom));
    endtask

    initial begin : stimulus
        int phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Errors and searches on an empty list.
        issue_op(pal_pkg::MODE_LOCATE, 4'd0, NAME_ANA, 24'h0, 8'd30, 16'h0);
        issue_op(pal_pkg::MODE_DELETE, 4'd1, NAME_ANA, 24'h0, 8'd30, 16'h0);
        issue_op(pal_pkg::MODE_INSERT, 4'd0, NAME_ANA, 24'h0, 8'd30, 16'h0);
        issue_op(pal_pkg::MODE_INSERT, 4'd2, NAME_ANA, 24'h0, 8'd30, 16'h0);
        // Fill the list: at the end, the front and the middle, with a duplicate key.
        issue_op(pal_pkg::MODE_INSERT, 4'd1, NAME_ANA, 24'h4D0000, 8'd30, 16'd100);
        issue_op(pal_pkg::MODE_INSERT, 4'd2, NAME_ONES, 24'hFFFFFF, 8'd255, 16'hFFFF);
        issue_op(pal_pkg::MODE_INSERT, 4'd1, 64'h0, 24'h0, 8'd0, 16'h0);
        issue_op(pal_pkg::MODE_INSERT, 4'd2, NAME_ANA, 24'h46, 8'd31, 16'd7);
        issue_op(pal_pkg::MODE_INSERT, 4'd5, NAME_BOB, 24'h4D, 8'd30, 16'd8);
        issue_op(pal_pkg::MODE_INSERT, 4'd3, NAME_ANA, 24'h46, 8'd30, 16'd9);
        issue_op(pal_pkg::MODE_INSERT, 4'd7, NAME_EVE, 24'h46, 8'd31, 16'd10);
        issue_op(pal_pkg::MODE_INSERT, 4'd8, NAME_EVE, 24'h4D, 8'd200, 16'd11);
        // A full list refuses inserts before looking at the position.
        issue_op(pal_pkg::MODE_INSERT, 4'd1, NAME_BOB, 24'h1, 8'd1, 16'd1);
        issue_op(pal_pkg::MODE_INSERT, 4'd0, NAME_BOB, 24'h1, 8'd1, 16'd1);
        issue_op(pal_pkg::MODE_INSERT, 4'd15, NAME_BOB, 24'h1, 8'd1, 16'd1);
        // Searches: first of duplicates, last cell, age mismatch, all-zero key.
        issue_op(pal_pkg::MODE_LOCATE, 4'd9, NAME_ANA, 24'h0, 8'd30, 16'h0);
        issue_op(pal_pkg::MODE_LOCATE, 4'd0, NAME_EVE, 24'h0, 8'd200, 16'h0);
        issue_op(pal_pkg::MODE_LOCATE, 4'd0, NAME_ANA, 24'h0, 8'd99, 16'h0);
        issue_op(pal_pkg::MODE_LOCATE, 4'd0, 64'h0, 24'h0, 8'd0, 16'h0);
        issue_op(pal_pkg::MODE_NOP, 4'd5, NAME_ANA, 24'h0, 8'd30, 16'h0);
        // Deletes: last cell of a full list, out-of-range positions, then the front cell.
        issue_op(pal_pkg::MODE_DELETE, 4'd8, NAME_ANA, 24'h0, 8'd0, 16'h0);
        issue_op(pal_pkg::MODE_DELETE, 4'd0, NAME_ANA, 24'h0, 8'd0, 16'h0);
        issue_op(pal_pkg::MODE_DELETE, 4'd15, NAME_ANA, 24'h0, 8'd0, 16'h0);
        issue_op(pal_pkg::MODE_DELETE, 4'd8, NAME_ANA, 24'h0, 8'd0, 16'h0);
        issue_op(pal_pkg::MODE_DELETE, 4'd1, NAME_ANA, 24'h0, 8'd0, 16'h0);

        // Random traffic under each idling pattern.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            repeat (RANDOM_PER_PHASE) random_op();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
